FILE: sv/multichannel_led_ramp_dimmer_defines.svh
// ---------------------------------------------------------------------------
// LED ramp dimmer assertion macros
// Shared property macros for the checker.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_LED_RAMP_DIMMER_DEFINES_SVH
`define MULTICHANNEL_LED_RAMP_DIMMER_DEFINES_SVH

// same-cycle implication
`define LRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lrd check failed");

// next-cycle implication
`define LRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lrd check failed");

`endif

FILE: sv/lrd_pkg.sv
// ---------------------------------------------------------------------------
// LED ramp dimmer package
// Beat types, channel state, codes and constants.
// ---------------------------------------------------------------------------
package lrd_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam logic [13:0] FULL_SCALE = 14'd10000;
	localparam logic [13:0] DEFAULT_STEP_RST = 14'd1;
	localparam logic [15:0] DEFAULT_SPEED_RST = 16'd100;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_UP   = 2'd2,
		MODE_DOWN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_ARM  = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		REG_DEFAULT_STEP  = 1'b0,
		REG_DEFAULT_SPEED = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  chan;
		mode_t       mode;
		logic [13:0] level;
		logic [13:0] target;
		logic [13:0] step;
		logic [15:0] speed;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  out_chan;
		mode_t       out_mode;
		logic [13:0] duty;
		logic        enabled;
		logic        mode_event;
		logic        last;
	} out_item_t;

	typedef struct packed {
		mode_t       mode;
		logic [13:0] level;
		logic [13:0] target;
		logic [13:0] step;
		logic [15:0] speed;
		logic [15:0] count;
	} chan_state_t;

	typedef struct packed {
		logic        is_tick;
		logic        chan_ok;
		logic [2:0]  rpt_chan;
		logic        is_last;
	} unit_ctl_t;

endpackage

FILE: sv/lrd_chan_unit.sv
// ---------------------------------------------------------------------------
// LED ramp dimmer channel unit
// Shared update logic applied to one channel per cycle while the output is free.
// ---------------------------------------------------------------------------
module lrd_chan_unit (
	input  lrd_pkg::chan_state_t cur,
	input  lrd_pkg::in_item_t    cmd,
	input  lrd_pkg::unit_ctl_t   ctl,
	input  logic [13:0]          dflt_step,
	input  logic [15:0]          dflt_speed,
	output lrd_pkg::chan_state_t nxt,
	output logic                 we,
	output lrd_pkg::out_item_t   res
);
	import lrd_pkg::*;

	logic [14:0] sum;
	logic [15:0] cnt_dec;
	logic [15:0] speed_sel;
	logic        acc;
	logic        ev;
	logic        show_ok;
	logic        arm_rej;

	assign sum       = {1'b0, cur.level} + {1'b0, cur.step};
	assign cnt_dec   = cur.count - 16'd1;
	assign speed_sel = (cmd.speed != 16'd0) ? cmd.speed : dflt_speed;
	assign arm_rej   = (cur.mode == MODE_OFF) || (cur.mode == MODE_ON) ||
		((cur.mode == MODE_UP) && (cur.level >= cmd.target)) ||
		((cur.mode == MODE_DOWN) && (cur.level < cmd.target));

	always_comb begin
		nxt     = cur;
		we      = 1'b0;
		acc     = 1'b0;
		ev      = 1'b0;
		show_ok = ctl.chan_ok;
		if (ctl.is_tick) begin
			acc     = 1'b1;
			show_ok = 1'b1;
			if ((cur.mode == MODE_UP || cur.mode == MODE_DOWN) && cur.count != 16'd0) begin
				we        = 1'b1;
				nxt.count = cnt_dec;
				if (cnt_dec == 16'd0) begin
					nxt.count = cur.speed;
					if (cur.mode == MODE_UP) begin
						if (cur.level < FULL_SCALE && cur.level < cur.target) begin
							nxt.level = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[13:0];
						end else begin
							nxt.mode = MODE_ON;
							ev       = 1'b1;
						end
					end else begin
						if (cur.level != 14'd0 && cur.level > cur.target) begin
							nxt.level = (cur.level > cur.step) ? cur.level - cur.step : 14'd0;
						end else begin
							nxt.mode = MODE_OFF;
							ev       = 1'b1;
						end
					end
				end
			end
		end else if (ctl.chan_ok && cmd.op == OP_SET) begin
			we        = 1'b1;
			acc       = 1'b1;
			ev        = 1'b1;
			nxt.mode  = cmd.mode;
			nxt.level = (cmd.level > FULL_SCALE) ? FULL_SCALE : cmd.level;
			if (cmd.mode == MODE_OFF || cmd.mode == MODE_ON) begin
				nxt.count = 16'd0;
			end
		end else if (ctl.chan_ok && cmd.op == OP_ARM && !arm_rej) begin
			we         = 1'b1;
			acc        = 1'b1;
			nxt.step   = (cmd.step != 14'd0) ? cmd.step : dflt_step;
			nxt.speed  = speed_sel;
			nxt.target = cmd.target;
			nxt.count  = speed_sel;
		end
	end

	always_comb begin
		res.accepted   = acc;
		res.out_chan   = ctl.rpt_chan;
		res.out_mode   = show_ok ? nxt.mode : MODE_OFF;
		res.duty       = show_ok ? nxt.level : 14'd0;
		res.enabled    = show_ok && (nxt.mode != MODE_OFF);
		res.mode_event = ev;
		res.last       = ctl.is_last;
	end

endmodule

FILE: sv/multichannel_led_ramp_dimmer.sv
// ---------------------------------------------------------------------------
// Multichannel LED ramp dimmer
// Per-channel mode, level and ramp sequencing with PWM period ticks.
// ---------------------------------------------------------------------------
// First result beat registered by the first work pass after accept, output free.
// Command: accept, then one channel unit pass; in_ready stays low until it ends.
// Tick: accept, then one channel unit pass per channel, in order.
// Output stalls hold the sequencer; one result beat buffered in the output reg.
// Reset: all channels off, level 0, step 1, speed 100, defaults 1 and 100.
module multichannel_led_ramp_dimmer #(
	parameter int CHANNELS = lrd_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lrd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lrd_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  lrd_pkg::reg_idx_t  cfg_addr,
	input  logic [15:0]        cfg_wdata
);
	import lrd_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	chan_state_t chan_q [CHANNELS];
	chan_state_t cur;
	chan_state_t nxt;
	seq_state_t  state_q;
	seq_state_t  state_d;
	in_item_t    cmd_q;
	out_item_t   out_q;
	out_item_t   res;
	unit_ctl_t   ctl;
	logic [13:0] dflt_step_q;
	logic [15:0] dflt_speed_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] sel;
	logic        out_valid_q;
	logic        out_free;
	logic        fire;
	logic        we;

	assign out_free     = !out_valid_q || out_ready;
	assign ctl.is_tick  = (cmd_q.op == OP_TICK);
	assign ctl.chan_ok  = ({1'b0, cmd_q.chan} < 4'(CHANNELS));
	assign ctl.rpt_chan = ctl.is_tick ? 3'(idx_q) : cmd_q.chan;
	assign ctl.is_last  = ctl.is_tick ? (idx_q == CW'(CHANNELS - 1)) : 1'b1;
	assign sel          = ctl.is_tick ? idx_q : cmd_q.chan[CW-1:0];
	assign cur          = chan_q[sel];

	lrd_chan_unit u_unit (
		.cur        (cur),
		.cmd        (cmd_q),
		.ctl        (ctl),
		.dflt_step  (dflt_step_q),
		.dflt_speed (dflt_speed_q),
		.nxt        (nxt),
		.we         (we),
		.res        (res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (out_free && ctl.is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		fire     = (state_q == ST_WORK) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			dflt_step_q  <= DEFAULT_STEP_RST;
			dflt_speed_q <= DEFAULT_SPEED_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= '{mode: MODE_OFF, level: 14'd0, target: 14'd0,
					step: DEFAULT_STEP_RST, speed: DEFAULT_SPEED_RST, count: 16'd0};
			end
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_addr == REG_DEFAULT_STEP) begin
				dflt_step_q <= cfg_wdata[13:0];
			end
			if (cfg_we && cfg_addr == REG_DEFAULT_SPEED) begin
				dflt_speed_q <= cfg_wdata;
			end
			if (fire) begin
				idx_q <= ctl.is_last ? '0 : idx_q + 1'b1;
				if (we) begin
					chan_q[sel] <= nxt;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_data;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/lrd_checker.sv
// ---------------------------------------------------------------------------
// LED ramp dimmer checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "multichannel_led_ramp_dimmer_defines.svh"

module lrd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input lrd_pkg::out_item_t out_data
);
	import lrd_pkg::*;

	`LRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`LRD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`LRD_ASSERT_NOW(a_reject_single, clk, arst_n, out_valid && !out_data.accepted, out_data.last)
	`LRD_ASSERT_NOW(a_enable_mode, clk, arst_n, out_valid, out_data.enabled == (out_data.out_mode != MODE_OFF))

endmodule

bind multichannel_led_ramp_dimmer lrd_checker u_lrd_checker (.*);
